// ===== src/pgcb_pkg.sv =====
// shared types, codes and defaults for the particle grid cell binner
`default_nettype none
package pgcb_pkg;

  // default sizing
  localparam int GRID_MAX_DEF     = 128;
  localparam int CELL_CAP_DEF     = 8;
  localparam int PARTICLE_MAX_DEF = 65536;

  // fixed payload widths
  localparam int IDX_W  = 8;
  localparam int PIDX_W = 16;
  localparam int POS_W  = 20;
  localparam int SIZE_W = 15;
  localparam int CFG_W  = 15;

  // register reset values
  localparam logic [7:0]        COLS_RESET   = 8'd100;
  localparam logic [7:0]        ROWS_RESET   = 8'd100;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 15'd1000;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 15'd1000;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CFG_COLS   = 2'd0,
    CFG_ROWS   = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_OUTSIDE    = 3'd1,
    ST_CELL_FULL  = 3'd2,
    ST_STORE_FULL = 3'd3,
    ST_HIT        = 3'd4,
    ST_NONE       = 3'd5
  } status_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              is_query;
    status_t           code;
    logic [PIDX_W-1:0] pidx;
    logic [IDX_W-1:0]  cx;
    logic [IDX_W-1:0]  cy;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_START,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_FREAD,
    B_FGET,
    B_INS,
    B_WALK,
    B_SGET,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== src/pgcb_ram.sv =====
// generic single write port memory with registered read
`default_nettype none
module pgcb_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== src/pgcb_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module pgcb_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 19
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic      [NUM_W-1:0] quo
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nshift;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   sh;
  logic             ge;

  // trial subtract
  assign sh = {rem, nshift[NUM_W-1]};
  assign ge = (sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NUM_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      nshift <= num;
      den_r  <= den;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      nshift <= {nshift[NUM_W-2:0], 1'b0};
      rem    <= ge ? DEN_W'(sh - {1'b0, den_r}) : DEN_W'(sh);
      quo    <= {quo[NUM_W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// ===== src/pgcb_front.sv =====
// front end: accepts items, bins coordinates and assigns particle indices
`default_nettype none
module pgcb_front #(
  parameter int GRID_MAX     = pgcb_pkg::GRID_MAX_DEF,
  parameter int PARTICLE_MAX = pgcb_pkg::PARTICLE_MAX_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                req_type,
  input  wire logic signed [pgcb_pkg::POS_W-1:0]   pos_x,
  input  wire logic signed [pgcb_pkg::POS_W-1:0]   pos_y,
  input  wire logic [$clog2(GRID_MAX+1)-1:0]       cols,
  input  wire logic [$clog2(GRID_MAX+1)-1:0]       rows,
  input  wire logic [pgcb_pkg::SIZE_W-1:0]         width,
  input  wire logic [pgcb_pkg::SIZE_W-1:0]         height,
  input  wire logic                                clearing,
  input  wire logic                                q_full,
  output logic                                     push,
  output pgcb_pkg::job_t                           push_job
);
  import pgcb_pkg::*;

  localparam int NW    = $clog2(GRID_MAX + 1);
  localparam int QW    = NW + POS_W;
  localparam int DEN_W = SIZE_W + 4;
  localparam int PTW   = $clog2(PARTICLE_MAX + 1);

  front_state_t      state, state_next;
  logic              is_query;
  logic              neg_x, neg_y;
  logic [POS_W-1:0]  mag_x, mag_y;
  logic [DEN_W-1:0]  den_x, den_y;
  logic [QW-1:0]     num_x, num_y;
  logic [QW-1:0]     q_x, q_y;
  logic              busy_x, busy_y;
  logic              div_start;
  logic [PTW-1:0]    total;
  logic              accept;
  logic              in_x, in_y, in_grid, store_full;
  logic [IDX_W-1:0]  idx_x, idx_y;

  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (accept) state_next = F_MUL;
      F_MUL:   state_next = F_START;
      F_START: state_next = F_DIV;
      F_DIV:   if (!busy_x && !busy_y) state_next = F_PUSH;
      F_PUSH:  if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state != F_IDLE) || clearing;
    div_start = (state == F_START);
    push      = (state == F_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      total <= '0;
    end else begin
      state <= state_next;
      if (push && !is_query && !store_full) begin
        total <= total + 1'b1;
      end
    end
  end

  // capture item: sign and magnitude, scaled image size
  always_ff @(posedge clk) begin
    if (accept) begin
      is_query <= req_type;
      neg_x    <= pos_x[POS_W-1];
      neg_y    <= pos_y[POS_W-1];
      mag_x    <= pos_x[POS_W-1] ? POS_W'(-pos_x) : POS_W'(pos_x);
      mag_y    <= pos_y[POS_W-1] ? POS_W'(-pos_y) : POS_W'(pos_y);
      den_x    <= {(width == '0) ? SIZE_W'(1) : width, 4'b0000};
      den_y    <= {(height == '0) ? SIZE_W'(1) : height, 4'b0000};
    end
    if (state == F_MUL) begin
      num_x <= QW'(cols) * QW'(mag_x);
      num_y <= QW'(rows) * QW'(mag_y);
    end
  end

  pgcb_div #(.NUM_W(QW), .DEN_W(DEN_W)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(num_x), .den(den_x),
    .busy(busy_x), .quo(q_x)
  );

  pgcb_div #(.NUM_W(QW), .DEN_W(DEN_W)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(num_y), .den(den_y),
    .busy(busy_y), .quo(q_y)
  );

  // classify: negatives inside only when they truncate to zero
  always_comb begin
    in_x       = neg_x ? (q_x == '0) : (q_x < QW'(cols));
    in_y       = neg_y ? (q_y == '0) : (q_y < QW'(rows));
    in_grid    = in_x && in_y;
    idx_x      = neg_x ? '0 : IDX_W'(q_x);
    idx_y      = neg_y ? '0 : IDX_W'(q_y);
    store_full = (32'(total) >= PARTICLE_MAX);
    push_job.is_query = is_query;
    if (!is_query && store_full) begin
      push_job.code = ST_STORE_FULL;
      push_job.pidx = '0;
      push_job.cx   = '0;
      push_job.cy   = '0;
    end else begin
      push_job.code = in_grid ? ST_STORED : ST_OUTSIDE;
      push_job.pidx = is_query ? '0 : PIDX_W'(total);
      push_job.cx   = in_grid ? idx_x : '0;
      push_job.cy   = in_grid ? idx_y : '0;
    end
  end
endmodule
`default_nettype wire

// ===== src/pgcb_queue.sv =====
// short fifo between front and back
`default_nettype none
module pgcb_queue #(
  parameter int W     = 32,
  parameter int DEPTH = pgcb_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic      [W-1:0] head,
  output logic              full,
  output logic              empty
);
  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end
endmodule
`default_nettype wire

// ===== src/pgcb_back.sv =====
// back end: cell lists, insert and neighborhood walk, output register
`default_nettype none
module pgcb_back #(
  parameter int GRID_MAX = pgcb_pkg::GRID_MAX_DEF,
  parameter int CELL_CAP = pgcb_pkg::CELL_CAP_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [$clog2(GRID_MAX+1)-1:0]   cols,
  input  wire logic [$clog2(GRID_MAX+1)-1:0]   rows,
  input  wire logic                            q_empty,
  input  wire pgcb_pkg::job_t                  q_job,
  output logic                                 q_pop,
  output logic                                 clearing,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [pgcb_pkg::PIDX_W-1:0]          particle_index,
  output logic [6:0]                           cell_col,
  output logic [6:0]                           cell_row,
  output logic [2:0]                           status,
  output logic                                 last
);
  import pgcb_pkg::*;

  localparam int NW      = $clog2(GRID_MAX + 1);
  localparam int CELLS   = GRID_MAX * GRID_MAX;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int SLOTS   = CELLS * CELL_CAP;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int CF_W    = $clog2(CELL_CAP + 1);
  localparam int NB      = 5;

  back_state_t       state, state_next;
  job_t              job;
  logic [IDX_W-1:0]  nx [NB];
  logic [IDX_W-1:0]  ny [NB];
  logic [CF_W-1:0]   cnt [NB];
  logic [2:0]        j;
  logic [CF_W-1:0]   i;
  logic [CELL_AW-1:0] clr_addr;
  logic              clr_done;
  logic [NB-1:0]     lz;
  status_t           pend_st;
  logic [PIDX_W-1:0] pend_pidx;
  logic [IDX_W-1:0]  pend_col, pend_row;
  status_t           out_st;

  logic              out_free, emit;
  logic              fill_we, fill_re, slot_we, slot_re;
  logic [CELL_AW-1:0] fill_waddr, fill_raddr, cell_j, cell_0;
  logic [CF_W-1:0]   fill_wdata, fill_rdata, fill_cl;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic [PIDX_W-1:0] slot_rdata;
  logic              cell_is_full, walk_has, hit_last;
  logic [IDX_W-1:0]  hx, hy, wx, wy;

  function automatic logic [CELL_AW-1:0] cell_addr(logic [IDX_W-1:0] x,
                                                   logic [IDX_W-1:0] y);
    cell_addr = CELL_AW'(x) * CELL_AW'(GRID_MAX) + CELL_AW'(y);
  endfunction

  function automatic logic [SLOT_AW-1:0] slot_addr(logic [CELL_AW-1:0] c,
                                                   logic [CF_W-1:0] k);
    slot_addr = SLOT_AW'(c) * SLOT_AW'(CELL_CAP) + SLOT_AW'(k);
  endfunction

  assign out_free     = !out_valid || !out_stall;
  assign cell_0       = cell_addr(nx[0], ny[0]);
  assign cell_j       = cell_addr(nx[j], ny[j]);
  assign clr_done     = (clr_addr == CELL_AW'(CELLS - 1));
  assign cell_is_full = (cnt[0] >= CF_W'(CELL_CAP));
  assign walk_has     = (i < cnt[j]);
  assign fill_cl      = (fill_rdata > CF_W'(CELL_CAP)) ? CF_W'(CELL_CAP) : fill_rdata;
  assign hit_last     = ((i + 1'b1) == cnt[j]) && lz[j];

  // no entries in any neighbor after each position
  always_comb begin
    for (int k = 0; k < NB; k++) begin
      lz[k] = 1'b1;
      for (int m = 0; m < NB; m++) begin
        if (m > k && cnt[m] != '0) lz[k] = 1'b0;
      end
    end
  end

  // wrapped neighbor coordinates of the head job
  always_comb begin
    hx = q_job.cx;
    hy = q_job.cy;
    wx = ((NW+1)'(hx) + 1'b1 == (NW+1)'(cols)) ? '0 : hx + 1'b1;
    wy = ((NW+1)'(hy) + 1'b1 == (NW+1)'(rows)) ? '0 : hy + 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_done) state_next = B_IDLE;
      B_IDLE: begin
        if (!q_empty) begin
          state_next = (q_job.code == ST_STORED) ? B_FREAD : B_EMIT;
        end
      end
      B_FREAD: state_next = B_FGET;
      B_FGET: begin
        if (!job.is_query) begin
          state_next = B_INS;
        end else if (j == 3'd0 && fill_rdata == '0) begin
          state_next = B_EMIT;
        end else if (j == 3'(NB - 1)) begin
          state_next = B_WALK;
        end else begin
          state_next = B_FREAD;
        end
      end
      B_INS:  if (out_free) state_next = B_IDLE;
      B_WALK: begin
        if (walk_has) state_next = B_SGET;
        else if (j == 3'(NB - 1)) state_next = B_IDLE;
      end
      B_SGET: if (out_free) state_next = hit_last ? B_IDLE : B_WALK;
      B_EMIT: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // memory controls and emission
  always_comb begin
    clearing   = (state == B_CLEAR);
    q_pop      = (state == B_IDLE) && !q_empty;
    emit       = out_free &&
                 (state == B_INS || state == B_SGET || state == B_EMIT);
    fill_re    = (state == B_FREAD);
    fill_raddr = cell_j;
    slot_we    = (state == B_INS) && out_free && !cell_is_full;
    slot_waddr = slot_addr(cell_0, cnt[0]);
    slot_re    = (state == B_WALK) && walk_has;
    slot_raddr = slot_addr(cell_j, i);
    fill_we    = clearing || slot_we;
    fill_waddr = clearing ? clr_addr : cell_0;
    fill_wdata = clearing ? '0 : cnt[0] + 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // job, counts and walk position
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job       <= q_job;
      pend_st   <= q_job.code;
      pend_pidx <= q_job.pidx;
      pend_col  <= q_job.cx;
      pend_row  <= q_job.cy;
      nx[0] <= hx;                              ny[0] <= hy;
      nx[1] <= (hx == '0) ? IDX_W'(cols - 1'b1) : hx - 1'b1;
      ny[1] <= wy;
      nx[2] <= hx;                              ny[2] <= wy;
      nx[3] <= wx;                              ny[3] <= wy;
      nx[4] <= wx;                              ny[4] <= hy;
      j     <= '0;
      i     <= '0;
    end
    if (state == B_FGET) begin
      cnt[j] <= fill_cl;
      if (job.is_query && j == 3'd0 && fill_rdata == '0) begin
        pend_st   <= ST_NONE;
        pend_pidx <= '0;
      end
      j <= (j == 3'(NB - 1)) ? '0 : j + 1'b1;
    end
    if (state == B_WALK && !walk_has) begin
      j <= j + 1'b1;
      i <= '0;
    end
    if (state == B_SGET && out_free) begin
      i <= i + 1'b1;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      unique case (state)
        B_INS: begin
          out_st         <= cell_is_full ? ST_CELL_FULL : ST_STORED;
          particle_index <= job.pidx;
          cell_col       <= 7'(job.cx);
          cell_row       <= 7'(job.cy);
          last           <= 1'b1;
        end
        B_SGET: begin
          out_st         <= ST_HIT;
          particle_index <= slot_rdata;
          cell_col       <= 7'(nx[j]);
          cell_row       <= 7'(ny[j]);
          last           <= hit_last;
        end
        default: begin
          out_st         <= pend_st;
          particle_index <= pend_pidx;
          cell_col       <= 7'(pend_col);
          cell_row       <= 7'(pend_row);
          last           <= 1'b1;
        end
      endcase
    end
  end

  assign status = out_st;

  pgcb_ram #(.W(CF_W), .DEPTH(CELLS)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .re(fill_re), .raddr(fill_raddr), .rdata(fill_rdata)
  );

  pgcb_ram #(.W(PIDX_W), .DEPTH(SLOTS)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(job.pidx),
    .re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
  );
endmodule
`default_nettype wire

// ===== src/particle_grid_cell_binner.sv =====
// Top level: configuration registers, front binning, queue and cell list back end.
// Front: one item is binned at a time, mostly spent in the two bit-serial
// coordinate dividers of NW + 20 quotient bits.
// Back: insert, or for a query reads of the five neighbor list counts and then
// the hits, one slot memory read at a time.
// Reset: synchronous; then a clearing pass over all GRID_MAX*GRID_MAX cells
// (16384 by default) zeroes the cell counts while in_stall stays high.
`default_nettype none
module particle_grid_cell_binner #(
  parameter int GRID_MAX     = pgcb_pkg::GRID_MAX_DEF,
  parameter int CELL_CAP     = pgcb_pkg::CELL_CAP_DEF,
  parameter int PARTICLE_MAX = pgcb_pkg::PARTICLE_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [pgcb_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              req_type,
  input  wire logic signed [pgcb_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [pgcb_pkg::POS_W-1:0] pos_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [pgcb_pkg::PIDX_W-1:0]            particle_index,
  output logic [6:0]                             cell_col,
  output logic [6:0]                             cell_row,
  output logic [2:0]                             status,
  output logic                                   last
);
  import pgcb_pkg::*;

  localparam int NW = $clog2(GRID_MAX + 1);

  logic [7:0]        grid_cols, grid_rows;
  logic [SIZE_W-1:0] image_width, image_height;
  logic [NW-1:0]     cols, rows;
  logic              clearing, q_full, q_empty, push, q_pop;
  job_t              push_job, q_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols    <= COLS_RESET;
      grid_rows    <= ROWS_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COLS:   grid_cols    <= cfg_data[7:0];
        CFG_ROWS:   grid_rows    <= cfg_data[7:0];
        CFG_WIDTH:  image_width  <= cfg_data;
        CFG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  // grid size clamped to 1..GRID_MAX
  always_comb begin
    if (grid_cols == '0) cols = NW'(1);
    else if (32'(grid_cols) > GRID_MAX) cols = NW'(GRID_MAX);
    else cols = NW'(grid_cols);
    if (grid_rows == '0) rows = NW'(1);
    else if (32'(grid_rows) > GRID_MAX) rows = NW'(GRID_MAX);
    else rows = NW'(grid_rows);
  end

  pgcb_front #(.GRID_MAX(GRID_MAX), .PARTICLE_MAX(PARTICLE_MAX)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y), .cols(cols),
    .rows(rows), .width(image_width), .height(image_height),
    .clearing(clearing), .q_full(q_full), .push(push), .push_job(push_job)
  );

  pgcb_queue #(.W($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_job), .pop(q_pop),
    .head(q_job), .full(q_full), .empty(q_empty)
  );

  pgcb_back #(.GRID_MAX(GRID_MAX), .CELL_CAP(CELL_CAP)) u_back (
    .clk(clk), .rst(rst), .cols(cols), .rows(rows), .q_empty(q_empty),
    .q_job(q_job), .q_pop(q_pop), .clearing(clearing),
    .out_valid(out_valid), .out_stall(out_stall),
    .particle_index(particle_index), .cell_col(cell_col),
    .cell_row(cell_row), .status(status), .last(last)
  );
endmodule
`default_nettype wire

// ===== src/pgcb_checker.sv =====
// port-level checks for the binner and their bind
`default_nettype none
module pgcb_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [pgcb_pkg::PIDX_W-1:0]       particle_index,
  input wire logic [6:0]                        cell_col,
  input wire logic [6:0]                        cell_row,
  input wire logic [2:0]                        status,
  input wire logic                              last
);
  import pgcb_pkg::*;

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(particle_index) &&
    $stable(status) && $stable(last))
    else $error("stalled result changed");

  // clearing pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken during clearing");

  // single-result outcomes always end the item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != 3'(ST_HIT)) |-> last)
    else $error("non-hit result not marked last");

  // outside and store-full results carry no cell
  a_no_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == 3'(ST_OUTSIDE) || status == 3'(ST_STORE_FULL))
    |-> cell_col == '0 && cell_row == '0)
    else $error("cell given for uncelled result");

  // store full gives index zero
  a_full_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == 3'(ST_STORE_FULL) |-> particle_index == '0)
    else $error("index on store full");
endmodule

bind particle_grid_cell_binner pgcb_checker u_pgcb_checker (.*);
`default_nettype wire
